>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/jpp_pkg.sv
// ----------------------------------------------------------------------------
// jpp_pkg
// types, codes and constants shared by the json pretty printer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jpp_pkg;

    localparam int DEF_MAX_DEPTH  = 15;
    localparam int DEF_MAX_INDENT = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHAR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NEWLINE = 2'd2;

    // register reset values
    localparam logic [7:0] CFG_CHAR_RST    = 8'd32;
    localparam logic [2:0] CFG_WIDTH_RST   = 3'd2;
    localparam logic       CFG_NEWLINE_RST = 1'b0;

    // characters
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       chunk_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       chunk_done;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CR,
        ST_LF,
        ST_INDENT,
        ST_BYTE,
        ST_SPACE
    } t_state;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_INPUT,
        EM_HELD,
        EM_CR,
        EM_LF,
        EM_INDENT,
        EM_SPACE
    } t_emit_sel;

    typedef struct packed {
        logic      in_ready;
        logic      accept;
        t_emit_sel emit_sel;
        logic      run_last;
        logic      cnt_clear;
        logic      cnt_step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic can_load;
        logic need_break;
        logic is_colon;
        logic held_colon;
        logic crlf;
        logic indent_empty;
        logic indent_done;
    } t_dp_status;

endpackage

>>> src/jpp_ctrl.sv
// ----------------------------------------------------------------------------
// jpp_ctrl
// sequencer for one input byte: optional line break, indent run, byte, space
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jpp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  jpp_pkg::t_dp_status i_status,
    output jpp_pkg::t_ctrl_cmd  o_cmd,
    output jpp_pkg::t_state     o_state
);

    jpp_pkg::t_state r_state;
    jpp_pkg::t_state n_state;
    logic            w_accept;

    assign w_accept = i_in_valid && i_status.can_load && (r_state == jpp_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jpp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jpp_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_status.need_break) begin
                        n_state = i_status.crlf ? jpp_pkg::ST_CR : jpp_pkg::ST_LF;
                    end else if (i_status.is_colon) begin
                        n_state = jpp_pkg::ST_SPACE;
                    end
                end
            end
            jpp_pkg::ST_CR: begin
                if (i_status.can_load) n_state = jpp_pkg::ST_LF;
            end
            jpp_pkg::ST_LF: begin
                if (i_status.can_load) begin
                    n_state = i_status.indent_empty ? jpp_pkg::ST_BYTE : jpp_pkg::ST_INDENT;
                end
            end
            jpp_pkg::ST_INDENT: begin
                if (i_status.can_load && i_status.indent_done) n_state = jpp_pkg::ST_BYTE;
            end
            jpp_pkg::ST_BYTE: begin
                if (i_status.can_load) begin
                    n_state = i_status.held_colon ? jpp_pkg::ST_SPACE : jpp_pkg::ST_IDLE;
                end
            end
            jpp_pkg::ST_SPACE: begin
                if (i_status.can_load) n_state = jpp_pkg::ST_IDLE;
            end
            default: n_state = jpp_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.emit_sel  = jpp_pkg::EM_NONE;
        o_cmd.in_ready  = i_status.can_load && (r_state == jpp_pkg::ST_IDLE);
        o_cmd.accept    = w_accept;
        unique case (r_state)
            jpp_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_status.need_break) begin
                        o_cmd.cnt_clear = 1'b1;
                    end else begin
                        o_cmd.emit_sel = jpp_pkg::EM_INPUT;
                        o_cmd.run_last = !i_status.is_colon;
                    end
                end
            end
            jpp_pkg::ST_CR: begin
                if (i_status.can_load) o_cmd.emit_sel = jpp_pkg::EM_CR;
            end
            jpp_pkg::ST_LF: begin
                if (i_status.can_load) begin
                    o_cmd.emit_sel  = jpp_pkg::EM_LF;
                    o_cmd.cnt_clear = 1'b1;
                end
            end
            jpp_pkg::ST_INDENT: begin
                if (i_status.can_load) begin
                    o_cmd.emit_sel = jpp_pkg::EM_INDENT;
                    o_cmd.cnt_step = 1'b1;
                end
            end
            jpp_pkg::ST_BYTE: begin
                if (i_status.can_load) begin
                    o_cmd.emit_sel = jpp_pkg::EM_HELD;
                    o_cmd.run_last = !i_status.held_colon;
                end
            end
            jpp_pkg::ST_SPACE: begin
                if (i_status.can_load) begin
                    o_cmd.emit_sel = jpp_pkg::EM_SPACE;
                    o_cmd.run_last = 1'b1;
                end
            end
            default: o_cmd.emit_sel = jpp_pkg::EM_NONE;
        endcase
    end

    assign o_state = r_state;

endmodule

>>> src/jpp_datapath.sv
// ----------------------------------------------------------------------------
// jpp_datapath
// config registers, parse flags, nesting level, indent counters, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jpp_datapath #(
    parameter int MAX_DEPTH  = jpp_pkg::DEF_MAX_DEPTH,
    parameter int MAX_INDENT = jpp_pkg::DEF_MAX_INDENT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [jpp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [jpp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  jpp_pkg::t_in_item                 i_in,
    input  logic                              i_out_stall,
    input  jpp_pkg::t_ctrl_cmd                i_cmd,
    output jpp_pkg::t_dp_status               o_status,
    output logic                              o_out_valid,
    output jpp_pkg::t_out_item                o_out
);

    localparam int UNIT_W = $clog2(MAX_DEPTH + 1);
    localparam int CHAR_W = $clog2(MAX_INDENT + 1);

    // configuration
    logic [7:0] r_cfg_char;
    logic [2:0] r_cfg_width;
    logic       r_cfg_crlf;

    // parse state
    logic       r_esc, n_esc;
    logic       r_instr, n_instr;
    logic       r_indp, n_indp;
    logic [7:0] r_level, n_level;

    // held item
    logic [7:0]        r_byte;
    logic              r_chunk;
    logic              r_colon;
    logic [UNIT_W-1:0] r_units;

    // indent run counters
    logic [CHAR_W-1:0] r_char_cnt;
    logic [UNIT_W-1:0] r_unit_cnt;

    // output register
    logic               r_out_valid;
    jpp_pkg::t_out_item r_out;

    logic              w_need_break;
    logic              w_is_colon;
    logic [7:0]        w_brk_level;
    logic [UNIT_W-1:0] w_units;
    logic [CHAR_W-1:0] w_width;
    logic [CHAR_W-1:0] w_width_m1;
    logic              w_char_wrap;
    logic              w_can_load;
    logic [7:0]        w_c;

    assign w_c = i_in.in_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_char  <= jpp_pkg::CFG_CHAR_RST;
            r_cfg_width <= jpp_pkg::CFG_WIDTH_RST;
            r_cfg_crlf  <= jpp_pkg::CFG_NEWLINE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                jpp_pkg::CFG_IDX_CHAR:    r_cfg_char  <= i_cfg_data;
                jpp_pkg::CFG_IDX_WIDTH:   r_cfg_width <= i_cfg_data[2:0];
                jpp_pkg::CFG_IDX_NEWLINE: r_cfg_crlf  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // byte classification against the current parse state
    always_comb begin
        n_esc        = r_esc;
        n_instr      = r_instr;
        n_indp       = r_indp;
        n_level      = r_level;
        w_need_break = 1'b0;
        w_is_colon   = 1'b0;
        w_brk_level  = r_level;
        priority if (r_esc) begin
            n_esc = 1'b0;
        end else if (r_instr) begin
            if (w_c == jpp_pkg::CH_BSLASH) begin
                n_esc = 1'b1;
            end else if (w_c == jpp_pkg::CH_QUOTE) begin
                n_instr = 1'b0;
            end
        end else if (w_c == jpp_pkg::CH_LBRACE || w_c == jpp_pkg::CH_LBRACKET) begin
            w_need_break = r_indp;
            if (r_level != 8'hFF) n_level = r_level + 8'd1;
            n_indp = 1'b1;
        end else if (w_c == jpp_pkg::CH_RBRACE || w_c == jpp_pkg::CH_RBRACKET) begin
            if (r_level != 8'd0) n_level = r_level - 8'd1;
            w_brk_level  = n_level;
            w_need_break = !r_indp;
            n_indp       = 1'b0;
        end else if (w_c == jpp_pkg::CH_COMMA) begin
            n_indp = 1'b1;
        end else if (w_c == jpp_pkg::CH_QUOTE) begin
            w_need_break = r_indp;
            n_indp       = 1'b0;
            n_instr      = 1'b1;
        end else if (w_c == jpp_pkg::CH_COLON) begin
            w_is_colon = 1'b1;
        end else begin
            w_need_break = r_indp;
            n_indp       = 1'b0;
        end
    end

    // indent geometry, clamped
    assign w_units    = (w_brk_level < MAX_DEPTH) ? UNIT_W'(w_brk_level) : UNIT_W'(MAX_DEPTH);
    assign w_width    = (r_cfg_width < MAX_INDENT) ? CHAR_W'(r_cfg_width) : CHAR_W'(MAX_INDENT);
    assign w_width_m1 = w_width - CHAR_W'(1);
    assign w_char_wrap = (r_char_cnt == w_width_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= 1'b0;
            r_instr <= 1'b0;
            r_indp  <= 1'b0;
            r_level <= 8'd0;
        end else if (i_cmd.accept) begin
            r_esc   <= n_esc;
            r_instr <= n_instr;
            r_indp  <= n_indp;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte  <= i_in.in_byte;
            r_chunk <= i_in.chunk_end;
            r_colon <= w_is_colon;
            r_units <= w_units;
        end
        if (i_cmd.cnt_clear) begin
            r_char_cnt <= '0;
            r_unit_cnt <= '0;
        end else if (i_cmd.cnt_step) begin
            if (w_char_wrap) begin
                r_char_cnt <= '0;
                r_unit_cnt <= r_unit_cnt + UNIT_W'(1);
            end else begin
                r_char_cnt <= r_char_cnt + CHAR_W'(1);
            end
        end
    end

    // output register
    assign w_can_load = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sel != jpp_pkg::EM_NONE) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.emit_sel)
            jpp_pkg::EM_NONE:   ;
            jpp_pkg::EM_INPUT:  r_out.out_byte <= i_in.in_byte;
            jpp_pkg::EM_HELD:   r_out.out_byte <= r_byte;
            jpp_pkg::EM_CR:     r_out.out_byte <= jpp_pkg::CH_CR;
            jpp_pkg::EM_LF:     r_out.out_byte <= jpp_pkg::CH_LF;
            jpp_pkg::EM_INDENT: r_out.out_byte <= r_cfg_char;
            jpp_pkg::EM_SPACE:  r_out.out_byte <= jpp_pkg::CH_SPACE;
            default: ;
        endcase
        if (i_cmd.emit_sel != jpp_pkg::EM_NONE) begin
            r_out.run_last   <= i_cmd.run_last;
            r_out.chunk_done <= i_cmd.run_last &&
                ((i_cmd.emit_sel == jpp_pkg::EM_INPUT) ? i_in.chunk_end : r_chunk);
        end
    end

    assign o_status.can_load     = w_can_load;
    assign o_status.need_break   = w_need_break;
    assign o_status.is_colon     = w_is_colon;
    assign o_status.held_colon   = r_colon;
    assign o_status.crlf         = r_cfg_crlf;
    assign o_status.indent_empty = (r_units == '0) || (w_width == '0);
    assign o_status.indent_done  = w_char_wrap && (r_unit_cnt == r_units - UNIT_W'(1));

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> src/json_pretty_printer.sv
// ----------------------------------------------------------------------------
// json_pretty_printer
// reindents a compact json byte stream, one input byte per transaction
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                payload
//  -------  ---------  -----------------------  ------------------------------
//  in       sink       i_in_valid / o_in_stall  i_in  (in_byte, chunk_end)
//  out      source     o_out_valid / i_out_stall o_out (out_byte, run_last,
//                                                       chunk_done)
//  cfg      sink       i_cfg_we                 i_cfg_idx, i_cfg_data
//
//  a byte with no line break before it is emitted alone, a colon as colon, space
//  a byte behind a line break runs as cr (if crlf), lf, units * width indent
//  chars, then the byte; the output register takes one byte per cycle unless stalled
//  reset (i_rst_n low, synchronous) clears parse flags and level, resets config
//  o_in_stall is high while a byte's run is in progress or the output is full
//  a stall on the output freezes the sequencer in place, nothing is dropped
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module json_pretty_printer #(
    parameter int MAX_DEPTH  = jpp_pkg::DEF_MAX_DEPTH,
    parameter int MAX_INDENT = jpp_pkg::DEF_MAX_INDENT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [jpp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jpp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input bytes
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  jpp_pkg::t_in_item              i_in,
    // formatted bytes
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output jpp_pkg::t_out_item             o_out
);

    jpp_pkg::t_ctrl_cmd  w_cmd;
    jpp_pkg::t_dp_status w_status;
    jpp_pkg::t_state     w_state;

    // controller: walks the break / indent / byte / space sequence
    jpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    // datapath: config, parse flags, nesting level, counters, output register
    jpp_datapath #(
        .MAX_DEPTH  (MAX_DEPTH),
        .MAX_INDENT (MAX_INDENT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    // new transactions only enter between runs
    assign o_in_stall = !w_cmd.in_ready;

    // back in idle, whatever still sits in the output closes the previous run
    `ASSERT_IMPLIES(a_idle_out_is_last, i_clk, i_rst_n, (w_state == jpp_pkg::ST_IDLE) && o_out_valid, o_out.run_last, "idle with an unfinished run in the output register")

    // the controller never loads a byte the output register cannot take
    `ASSERT_IMPLIES(a_emit_has_room, i_clk, i_rst_n, w_cmd.emit_sel != jpp_pkg::EM_NONE, w_status.can_load, "byte emitted into a full output register")

    // an accepted transaction always starts from idle
    `ASSERT_IMPLIES(a_accept_in_idle, i_clk, i_rst_n, i_in_valid && !o_in_stall, w_state == jpp_pkg::ST_IDLE, "input accepted in the middle of a run")

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json pretty printer testbench
// feeds directed and random json byte streams through the formatter under
// several indent settings, predicts every formatted byte in a scoreboard and
// checks each output transaction against it, with random idling on both sides
// ----------------------------------------------------------------------------

module testbench;

    // ------------------------------------------------------------------------
    // scoreboard: tracks the formatter's parse state and indent settings,
    // turns each accepted input byte into the run of bytes it must produce
    // ------------------------------------------------------------------------
    class layout_scoreboard;
        jpp_pkg::t_out_item expected_text_q[$];
        jpp_pkg::t_out_item run_q[$];
        int                 error_count;

        // parse state
        bit         esc_next;
        bit         in_string;
        bit         break_armed;
        logic [7:0] depth_level;

        // indent settings
        logic [7:0] unit_char;
        logic [2:0] unit_width;
        logic       crlf_mode;

        function new();
            error_count = 0;
            esc_next    = 1'b0;
            in_string   = 1'b0;
            break_armed = 1'b0;
            depth_level = 8'd0;
            unit_char   = jpp_pkg::CFG_CHAR_RST;
            unit_width  = jpp_pkg::CFG_WIDTH_RST;
            crlf_mode   = jpp_pkg::CFG_NEWLINE_RST;
        endfunction

        function void set_reg(logic [jpp_pkg::CFG_IDX_W-1:0] idx,
                              logic [jpp_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                jpp_pkg::CFG_IDX_CHAR:    unit_char  = data;
                jpp_pkg::CFG_IDX_WIDTH:   unit_width = data[2:0];
                jpp_pkg::CFG_IDX_NEWLINE: crlf_mode  = data[0];
                default: ;  // unused index, no effect
            endcase
        endfunction

        function void add_byte(logic [7:0] b);
            jpp_pkg::t_out_item o;
            o.out_byte   = b;
            o.run_last   = 1'b0;
            o.chunk_done = 1'b0;
            run_q.push_back(o);
        endfunction

        // newline, then capped level times capped width copies of the indent char
        function void add_break();
            int units;
            int per_unit;
            units    = (depth_level < jpp_pkg::DEF_MAX_DEPTH) ?
                       depth_level : jpp_pkg::DEF_MAX_DEPTH;
            per_unit = (unit_width < jpp_pkg::DEF_MAX_INDENT) ?
                       unit_width : jpp_pkg::DEF_MAX_INDENT;
            if (crlf_mode)
                add_byte(jpp_pkg::CH_CR);
            add_byte(jpp_pkg::CH_LF);
            repeat (units * per_unit)
                add_byte(unit_char);
        endfunction

        function void note_byte(jpp_pkg::t_in_item item);
            logic [7:0] c;
            c = item.in_byte;
            run_q.delete();
            if (esc_next) begin
                esc_next = 1'b0;
                add_byte(c);
            end else if (in_string) begin
                if (c == jpp_pkg::CH_BSLASH)
                    esc_next = 1'b1;
                else if (c == jpp_pkg::CH_QUOTE)
                    in_string = 1'b0;
                add_byte(c);
            end else begin
                case (c)
                    jpp_pkg::CH_LBRACE, jpp_pkg::CH_LBRACKET: begin
                        if (break_armed)
                            add_break();
                        if (depth_level != 8'd255)
                            depth_level++;
                        break_armed = 1'b1;
                        add_byte(c);
                    end
                    jpp_pkg::CH_RBRACE, jpp_pkg::CH_RBRACKET: begin
                        if (depth_level != 8'd0)
                            depth_level--;
                        if (!break_armed)
                            add_break();
                        add_byte(c);
                        break_armed = 1'b0;
                    end
                    jpp_pkg::CH_COMMA: begin
                        break_armed = 1'b1;
                        add_byte(c);
                    end
                    jpp_pkg::CH_QUOTE: begin
                        if (break_armed)
                            add_break();
                        add_byte(c);
                        break_armed = 1'b0;
                        in_string   = 1'b1;
                    end
                    jpp_pkg::CH_COLON: begin
                        add_byte(jpp_pkg::CH_COLON);
                        add_byte(jpp_pkg::CH_SPACE);
                    end
                    default: begin
                        if (break_armed) begin
                            add_break();
                            break_armed = 1'b0;
                        end
                        add_byte(c);
                    end
                endcase
            end
            run_q[run_q.size()-1].run_last   = 1'b1;
            run_q[run_q.size()-1].chunk_done = item.chunk_end;
            foreach (run_q[i])
                expected_text_q.push_back(run_q[i]);
        endfunction

        function void check_output(jpp_pkg::t_out_item got);
            jpp_pkg::t_out_item exp_item;
            if (expected_text_q.size() == 0) begin
                $error("unexpected output transaction: out_byte %h", got.out_byte);
                error_count++;
                return;
            end
            exp_item = expected_text_q.pop_front();
            if (got.out_byte !== exp_item.out_byte) begin
                $error("out_byte mismatch: expected %h, actual %h",
                       exp_item.out_byte, got.out_byte);
                error_count++;
            end
            if (got.run_last !== exp_item.run_last) begin
                $error("run_last mismatch: expected %b, actual %b",
                       exp_item.run_last, got.run_last);
                error_count++;
            end
            if (got.chunk_done !== exp_item.chunk_done) begin
                $error("chunk_done mismatch: expected %b, actual %b",
                       exp_item.chunk_done, got.chunk_done);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_text_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [jpp_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [jpp_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    jpp_pkg::t_in_item              i_in        = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    jpp_pkg::t_out_item             o_out;

    layout_scoreboard      sb;

    // idling controls for the two sides
    bit in_idle_en  = 1'b1;
    bit out_idle_en = 1'b1;
    bit hold_req    = 1'b0;   // asks the output side for one long back-pressure stretch

    // bytes of the next stream to send
    logic [7:0] json_text_q[$];

    json_pretty_printer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit: far beyond the slowest legal run, every byte behind a full
    // 62-byte line break with heavy output stalls
    initial begin
        #6_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // output side: random stall, one long hold on request, checks every
    // accepted output transaction
    // ------------------------------------------------------------------------
    initial begin : out_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            // values seen here are the ones from just before the edge
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_output(o_out);
            if (hold_req && hold_left == 0) begin
                hold_req  = 1'b0;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= out_idle_en && ($urandom_range(99) < 23);
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offer one byte and wait until the transaction is taken; valid stays
    // high on return so back-to-back bytes need no gap
    task automatic send_json_byte(jpp_pkg::t_in_item item);
        if (in_idle_en && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 50);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_byte(item);
    endtask

    // send the queued stream, chunk ends at random and always on the last byte
    task automatic send_json_text();
        jpp_pkg::t_in_item item;
        foreach (json_text_q[i]) begin
            item.in_byte   = json_text_q[i];
            item.chunk_end = (i == json_text_q.size() - 1) || ($urandom_range(3) == 0);
            send_json_byte(item);
        end
        json_text_q.delete();
        i_in_valid <= 1'b0;
    endtask

    // wait for every predicted byte, then let the sequencer settle back to idle
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write, one per clock edge; caller drops the enable afterwards
    task automatic write_format_reg(logic [jpp_pkg::CFG_IDX_W-1:0] idx,
                                    logic [jpp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic set_format(logic [7:0] ch, logic [7:0] wid, logic [7:0] nl);
        write_format_reg(jpp_pkg::CFG_IDX_CHAR, ch);
        write_format_reg(jpp_pkg::CFG_IDX_WIDTH, wid);
        write_format_reg(jpp_pkg::CFG_IDX_NEWLINE, nl);
        i_cfg_we <= 1'b0;
    endtask

    // mostly well-formed json with random content: containers, keys, strings
    // with escapes, scalars, whitespace, plus some stray closes and raw noise
    task automatic build_json_text(int target, int open_pct);
        int depth;
        int r;
        int len;
        int k;
        logic [7:0] ws [4];
        ws    = '{jpp_pkg::CH_SPACE, 8'h09, jpp_pkg::CH_LF, jpp_pkg::CH_CR};
        depth = 0;
        while (json_text_q.size() < target) begin
            r = $urandom_range(99);
            if (r < open_pct) begin
                json_text_q.push_back($urandom_range(1) ?
                                      jpp_pkg::CH_LBRACE : jpp_pkg::CH_LBRACKET);
                depth++;
            end else if (r < open_pct + 15) begin
                // a close at depth zero now and then hits the floor of the level
                if (depth > 0 || $urandom_range(4) == 0) begin
                    json_text_q.push_back($urandom_range(1) ?
                                          jpp_pkg::CH_RBRACE : jpp_pkg::CH_RBRACKET);
                    if (depth > 0)
                        depth--;
                end
            end else if (r < open_pct + 27) begin
                json_text_q.push_back(jpp_pkg::CH_COMMA);
            end else if (r < open_pct + 34) begin
                json_text_q.push_back(jpp_pkg::CH_COLON);
            end else if (r < open_pct + 54) begin
                json_text_q.push_back(jpp_pkg::CH_QUOTE);
                len = $urandom_range(6);
                repeat (len) begin
                    k = $urandom_range(9);
                    if (k == 0) begin
                        // escape followed by any byte, quote included
                        json_text_q.push_back(jpp_pkg::CH_BSLASH);
                        json_text_q.push_back(8'($urandom_range(255)));
                    end else if (k == 1) begin
                        json_text_q.push_back(8'($urandom_range(255)));
                    end else begin
                        json_text_q.push_back(8'(8'h61 + $urandom_range(25)));
                    end
                end
                json_text_q.push_back(jpp_pkg::CH_QUOTE);
            end else if (r < open_pct + 67) begin
                len = $urandom_range(1, 4);
                repeat (len)
                    json_text_q.push_back(8'(8'h30 + $urandom_range(9)));
            end else if (r < open_pct + 74) begin
                json_text_q.push_back(ws[$urandom_range(3)]);
            end else begin
                json_text_q.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int guard;
        sb = new();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed stream at reset settings: close at level zero, extreme
        // bytes outside and inside strings, empty containers, escaped quote,
        // colon, comma and nested key/value
        json_text_q = '{jpp_pkg::CH_RBRACKET, 8'h00, 8'hFF, jpp_pkg::CH_LBRACE,
                        jpp_pkg::CH_RBRACE, jpp_pkg::CH_LBRACKET, 8'h31,
                        jpp_pkg::CH_COMMA, jpp_pkg::CH_QUOTE, jpp_pkg::CH_BSLASH,
                        jpp_pkg::CH_QUOTE, 8'hFF, 8'h00, jpp_pkg::CH_QUOTE,
                        jpp_pkg::CH_COLON, jpp_pkg::CH_SPACE, jpp_pkg::CH_LBRACE,
                        jpp_pkg::CH_QUOTE, 8'h6B, jpp_pkg::CH_QUOTE,
                        jpp_pkg::CH_COLON, jpp_pkg::CH_LBRACKET,
                        jpp_pkg::CH_RBRACKET, jpp_pkg::CH_RBRACE,
                        jpp_pkg::CH_RBRACKET};
        send_json_text();
        wait_drained();

        // dot indent, one per level, cr lf; long output hold while the
        // input side keeps offering so the formatter backs up
        set_format(8'h2E, 8'd1, 8'd1);
        hold_req = 1'b1;
        build_json_text(50, 18);
        send_json_text();
        wait_drained();

        // unused index written first, then all-ones char, width beyond the
        // cap, lf via a masked write; deep-biased nesting with no idling
        write_format_reg(2'd3, 8'($urandom_range(255)));
        set_format(8'hFF, 8'hFF, 8'hFE);
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        build_json_text(50, 32);
        send_json_text();
        wait_drained();
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;

        // zero char, zero width, cr lf
        set_format(8'h00, 8'd0, 8'd1);
        build_json_text(50, 18);
        send_json_text();
        wait_drained();

        // push the level past the depth cap with cheap zero-width breaks
        set_format(8'h41, 8'd0, 8'd0);
        repeat (20)
            json_text_q.push_back(jpp_pkg::CH_LBRACKET);
        send_json_text();
        wait_drained();

        // beyond the depth cap with the widest indent: full-size line breaks,
        // an open that goes deeper still, then commas, a digit, a string, a colon and a close
        set_format(8'h2D, 8'd4, 8'd1);
        json_text_q = '{jpp_pkg::CH_LBRACKET, jpp_pkg::CH_COMMA, 8'h37,
                        jpp_pkg::CH_COMMA, jpp_pkg::CH_QUOTE, jpp_pkg::CH_BSLASH,
                        jpp_pkg::CH_QUOTE, jpp_pkg::CH_QUOTE, jpp_pkg::CH_COLON,
                        jpp_pkg::CH_RBRACE};
        send_json_text();

        // drain with a limit, then let the latency of a full break pass
        guard = 0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (70) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected output transactions never arrived", sb.pending());
            sb.error_count++;
        end

        if (sb.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/jpp_pkg.sv
src/jpp_ctrl.sv
src/jpp_datapath.sv
src/json_pretty_printer.sv
tb/sv/testbench.sv
